FILE: hdl/betn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package betn_pkg;

  localparam int unsigned DeltaW = 32;
  localparam int unsigned FlagsW = 4;
  localparam int unsigned MaxResults = 3;

  // Flag bit positions.
  localparam int unsigned FSdaLvl = 0;
  localparam int unsigned FSdaEdg = 1;
  localparam int unsigned FSclLvl = 2;
  localparam int unsigned FSclEdg = 3;

  // Register indexes.
  localparam logic RegMergeEdges  = 1'b0;
  localparam logic RegSplitMerged = 1'b1;

  typedef logic [DeltaW-1:0] delta_t;
  typedef logic [FlagsW-1:0] flags_t;

  typedef struct packed {
    logic   has_event;
    delta_t delta;
    flags_t flags;
    logic   run_last;
    logic   trace_end;
  } result_t;

  typedef struct packed {
    logic   emit;
    delta_t emit_delta;
    flags_t emit_flags;
    logic   held_valid;
    delta_t held_delta;
    flags_t held_flags;
  } feed_t;

  function automatic logic edge_while_low(input flags_t f);
    return !f[FSclLvl] && f[FSdaEdg];
  endfunction

  // One event through the one-word hold stage.
  function automatic feed_t feed(input logic hv, input delta_t hd, input flags_t hf,
                                 input delta_t d, input flags_t f, input logic merge);
    feed_t r;
    r.emit       = 1'b0;
    r.emit_delta = hd;
    r.emit_flags = hf;
    r.held_valid = 1'b1;
    r.held_delta = d;
    r.held_flags = f;
    if (hv) begin
      if (merge && edge_while_low(hf) && edge_while_low(f) &&
          (hf[FSclEdg:FSclLvl] == f[FSclEdg:FSclLvl])) begin
        r.held_valid = 1'b0;
        r.held_delta = hd;
        r.held_flags = hf;
      end else begin
        r.emit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bus_edge_trace_normalizer.sv
// The first result of an accepted word passes through the input register and then the
// result buffer before it appears at the output.
// Throughput: one word per cycle while out_ready is high and each word yields at most
// one result; a word with several results holds the single output port until taken.
// Reset (synchronous, active high) empties the hold stage and both buffers and sets
// merge_edges and split_merged to 1.
`timescale 1ns / 1ps
`default_nettype none

module bus_edge_trace_normalizer import betn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [31:0] in_delta,
  input  wire logic        in_sda_level,
  input  wire logic        in_sda_edge,
  input  wire logic        in_scl_level,
  input  wire logic        in_scl_edge,
  input  wire logic        in_trace_last,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        has_event,
  output      logic [31:0] out_delta,
  output      logic        out_sda_level,
  output      logic        out_sda_edge,
  output      logic        out_scl_level,
  output      logic        out_scl_edge,
  output      logic        run_last,
  output      logic        trace_end
);

  logic merge_edges;
  logic split_merged;

  logic   s1_valid;
  delta_t s1_delta;
  flags_t s1_flags;
  logic   s1_last;

  logic   held_valid;
  delta_t held_delta;
  flags_t held_flags;

  result_t     rbuf [MaxResults];
  result_t     res_next [MaxResults];
  logic [1:0]  cnt;
  logic [1:0]  cnt_next;
  logic [1:0]  n;

  logic   pop;
  logic   load;
  logic   wr_en;
  logic   sp;
  flags_t inv;
  flags_t first;
  flags_t second;
  feed_t  fe1;
  feed_t  fe2;
  logic   emit2;
  logic   fin_valid;
  delta_t fin_delta;
  flags_t fin_flags;
  result_t res_a;
  result_t res_b;
  result_t res_c;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = {31'd0, (paddr[2] == RegSplitMerged) ? split_merged : merge_edges};

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_edges  <= 1'b1;
      split_merged <= 1'b1;
    end else if (wr_en) begin
      case (paddr[2])
        RegMergeEdges:  merge_edges  <= pwdata[0];
        RegSplitMerged: split_merged <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign pop       = out_valid && out_ready;
  assign load      = s1_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && pop));
  assign in_ready  = !s1_valid || load;
  assign out_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_delta <= in_delta;
      s1_flags <= {in_scl_edge, in_scl_level, in_sda_edge, in_sda_level};
      s1_last  <= in_trace_last;
    end
  end

  always_comb begin
    inv = ~s1_flags;
    sp  = split_merged && s1_flags[FSdaEdg] && s1_flags[FSclEdg];
    if (s1_flags[FSclLvl]) begin
      first  = {inv[FSclEdg], inv[FSclLvl], s1_flags[FSdaEdg], s1_flags[FSdaLvl]};
      second = {s1_flags[FSclEdg], s1_flags[FSclLvl], 1'b0, s1_flags[FSdaLvl]};
    end else begin
      first  = {s1_flags[FSclEdg], s1_flags[FSclLvl], inv[FSdaEdg], inv[FSdaLvl]};
      second = {1'b0, s1_flags[FSclLvl], s1_flags[FSdaEdg], s1_flags[FSdaLvl]};
    end
    fe1 = feed(held_valid, held_delta, held_flags, s1_delta, sp ? first : s1_flags,
               merge_edges);
    fe2 = feed(fe1.held_valid, fe1.held_delta, fe1.held_flags, '0, second, merge_edges);
    emit2 = sp && fe2.emit;
    if (sp) begin
      fin_valid = fe2.held_valid;
      fin_delta = fe2.held_delta;
      fin_flags = fe2.held_flags;
    end else begin
      fin_valid = fe1.held_valid;
      fin_delta = fe1.held_delta;
      fin_flags = fe1.held_flags;
    end

    res_a = '{has_event: 1'b1, delta: fe1.emit_delta, flags: fe1.emit_flags,
              run_last: 1'b0, trace_end: 1'b0};
    res_b = '{has_event: 1'b1, delta: fe2.emit_delta, flags: fe2.emit_flags,
              run_last: 1'b0, trace_end: 1'b0};
    res_c = '{has_event: fin_valid, delta: fin_valid ? fin_delta : '0,
              flags: fin_valid ? fin_flags : '0, run_last: 1'b0, trace_end: 1'b0};

    n = {1'b0, fe1.emit} + {1'b0, emit2} + {1'b0, s1_last};

    res_next[0] = fe1.emit ? res_a : (emit2 ? res_b : res_c);
    res_next[1] = (fe1.emit && emit2) ? res_b : res_c;
    res_next[2] = res_c;
    for (int i = 0; i < MaxResults; i++) begin
      if ((n != 2'd0) && (2'(i) == (n - 2'd1))) begin
        res_next[i].run_last  = 1'b1;
        res_next[i].trace_end = s1_last;
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (load) begin
      cnt_next = n;
    end else if (pop) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= 2'd0;
      held_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (load) begin
        held_valid <= fin_valid && !s1_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_delta <= '0;
      held_flags <= '0;
    end else if (load) begin
      held_delta <= s1_last ? '0 : fin_delta;
      held_flags <= s1_last ? '0 : fin_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rbuf <= res_next;
    end else if (pop) begin
      rbuf[0] <= rbuf[1];
      rbuf[1] <= rbuf[2];
    end
  end

  assign has_event     = rbuf[0].has_event;
  assign out_delta     = rbuf[0].delta;
  assign out_sda_level = rbuf[0].flags[FSdaLvl];
  assign out_sda_edge  = rbuf[0].flags[FSdaEdg];
  assign out_scl_level = rbuf[0].flags[FSclLvl];
  assign out_scl_edge  = rbuf[0].flags[FSclEdg];
  assign run_last      = rbuf[0].run_last;
  assign trace_end     = rbuf[0].trace_end;

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && trace_end |-> run_last)
    else $error("trace end result without run_last");

  a_marker_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_event |-> trace_end && (out_delta == '0) &&
      !out_sda_level && !out_sda_edge && !out_scl_level && !out_scl_edge)
    else $error("bare end marker carries data");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    load && s1_last |=> !held_valid)
    else $error("hold stage not empty after flush");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !load |=> s1_valid && $stable(s1_delta) && $stable(s1_flags))
    else $error("input stage lost a word");

endmodule

`default_nettype wire
